// ===== rtl/core/tcce_pkg.sv =====
// Shared types, constants and codes of the text console cursor engine.
// No dependencies; every other file of the block imports this package.
package tcce_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);

  // Port field widths.
  localparam int KIND_W   = 2;
  localparam int CH_W     = 8;
  localparam int RROW_W   = 5;
  localparam int RCOL_W   = 7;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;

  // Depth of the command queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 2;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Character codes.
  localparam logic [CH_W-1:0] CH_BS    = 8'h08;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_LAST  = 8'h7F;

  localparam logic [CH_W-1:0] ATTR_BYTE = 8'h0F;
  localparam int              TAB_MASK  = 8 - 1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_BS,
    OP_TAB,
    OP_CR,
    OP_LF,
    OP_PRINT,
    OP_CLEAR,
    OP_READ
  } tcce_op_t;

  typedef struct packed {
    tcce_op_t         op;
    logic [CH_W-1:0]  ch;
    logic [ROW_W-1:0] rd_row;
    logic [COL_W-1:0] rd_col;
    logic             rd_ok;
  } tcce_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP
  } tcce_state_t;

endpackage

// ===== rtl/core/tcce_req_if.sv =====
// Request channel of the console engine: valid/ready plus one input item.
// Field widths come from tcce_pkg.
interface tcce_req_if;
  import tcce_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CH_W-1:0]   ch;
  logic [RROW_W-1:0] read_row;
  logic [RCOL_W-1:0] read_col;

  modport source (output valid, kind, ch, read_row, read_col, input ready);
  modport sink   (input valid, kind, ch, read_row, read_col, output ready);
endinterface

// ===== rtl/core/tcce_rsp_if.sv =====
// Response channel of the console engine: valid/ready plus one result item.
// Field widths come from tcce_pkg.
interface tcce_rsp_if;
  import tcce_pkg::*;

  logic                valid;
  logic                ready;
  logic [CURSOR_W-1:0] cursor_loc;
  logic [CELL_W-1:0]   cell_word;

  modport source (output valid, cursor_loc, cell_word, input ready);
  modport sink   (input valid, cursor_loc, cell_word, output ready);
endinterface

// ===== rtl/core/tcce_front.sv =====
// Front end: accepts request transfers, decodes them into queue commands.
// Depends on tcce_pkg and tcce_req_if.
module tcce_front (
  input  logic                clk,
  input  logic                rst,
  tcce_req_if.sink            req,
  output tcce_pkg::tcce_cmd_t cmd,
  output logic                cmd_valid,
  input  logic                cmd_ready
);
  import tcce_pkg::*;

  tcce_cmd_t decoded;
  logic      hold_valid;
  tcce_cmd_t hold;

  always_comb begin
    decoded.ch     = req.ch;
    decoded.rd_row = ROW_W'(req.read_row);
    decoded.rd_col = COL_W'(req.read_col);
    decoded.rd_ok  = (int'(req.read_row) < ROWS) && (int'(req.read_col) < COLUMNS);
    case (req.kind)
      KIND_PUT: begin
        if (req.ch == CH_BS) begin
          decoded.op = OP_BS;
        end else if (req.ch == CH_TAB) begin
          decoded.op = OP_TAB;
        end else if (req.ch == CH_CR) begin
          decoded.op = OP_CR;
        end else if (req.ch == CH_LF) begin
          decoded.op = OP_LF;
        end else if (req.ch inside {[CH_SPACE:CH_LAST]}) begin
          decoded.op = OP_PRINT;
        end else begin
          decoded.op = OP_NOP;
        end
      end
      KIND_CLEAR: decoded.op = OP_CLEAR;
      KIND_READ:  decoded.op = OP_READ;
      default:    decoded.op = OP_NOP;
    endcase
  end

  assign req.ready = !hold_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req.ready) begin
      hold_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      hold <= decoded;
    end
  end

  assign cmd       = hold;
  assign cmd_valid = hold_valid;

endmodule

// ===== rtl/core/tcce_queue.sv =====
// Short command queue that decouples the front end from the back end.
// Depends on tcce_pkg for the command type and depth.
module tcce_queue (
  input  logic                clk,
  input  logic                rst,
  input  tcce_pkg::tcce_cmd_t push_cmd,
  input  logic                push_valid,
  output logic                push_ready,
  output tcce_pkg::tcce_cmd_t pop_cmd,
  output logic                pop_valid,
  input  logic                pop_ready
);
  import tcce_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tcce_cmd_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/tcce_back.sv =====
// Back end: cursor, row ring, per-row valid bits, screen memory and the
// result register. Depends on tcce_pkg and tcce_rsp_if.
module tcce_back (
  input  logic                clk,
  input  logic                rst,
  input  tcce_pkg::tcce_cmd_t cmd,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  tcce_rsp_if.source          rsp
);
  import tcce_pkg::*;

  // Physical row of a logical row, given the ring's top row.
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] t);
    logic [ROW_W:0] sum;
    sum = {1'b0, r} + {1'b0, t};
    if (int'(sum) >= ROWS) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] pr,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(int'(pr) * COLUMNS + int'(c));
  endfunction

  tcce_state_t      state, state_next;
  logic [ROW_W-1:0] row, row_next;
  logic [COL_W-1:0] col, col_next;
  logic [ROW_W-1:0] top, top_next;
  logic [ROWS-1:0]  row_ok, row_ok_next;
  logic [COL_W-1:0] sweep_cnt, sweep_next;

  logic                out_valid;
  logic [CURSOR_W-1:0] out_pos;
  logic [CELL_W-1:0]   out_cell;
  logic                out_free;
  logic                load_out;
  logic [CELL_W-1:0]   cell_next;
  logic [CURSOR_W-1:0] pos_next;

  // Screen memory holds only the character byte; the attribute is fixed.
  logic [CH_W-1:0]   mem [CELLS];
  logic [CH_W-1:0]   rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CH_W-1:0]   mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic [ROW_W-1:0] cur_phys;
  logic [ROW_W-1:0] rd_phys;
  logic             row_adv;
  logic [COL_W:0]   tab_col;

  assign out_free = !out_valid || rsp.ready;
  assign cur_phys = phys_row(row, top);
  assign rd_phys  = phys_row(cmd.rd_row, top);
  assign tab_col  = ({1'b0, col} + (COL_W+1)'(8)) & ~(COL_W+1)'(TAB_MASK);

  always_comb begin
    state_next  = state;
    row_next    = row;
    col_next    = col;
    top_next    = top;
    row_ok_next = row_ok;
    sweep_next  = sweep_cnt;
    cmd_pop     = 1'b0;
    load_out    = 1'b0;
    cell_next   = '0;
    row_adv     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cell_addr(cur_phys, col);
    mem_wdata   = cmd.ch;
    mem_re      = 1'b0;
    mem_raddr   = cell_addr(rd_phys, cmd.rd_col);

    case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          case (cmd.op)
            OP_PRINT: begin
              // A row blanked by clear or scroll is swept before its first write.
              if (!row_ok[cur_phys]) begin
                state_next = ST_SWEEP;
                sweep_next = '0;
              end else begin
                mem_we   = 1'b1;
                cmd_pop  = 1'b1;
                load_out = 1'b1;
                if (int'(col) == COLUMNS - 1) begin
                  col_next = '0;
                  row_adv  = 1'b1;
                end else begin
                  col_next = col + COL_W'(1);
                end
              end
            end
            OP_BS: begin
              cmd_pop  = 1'b1;
              load_out = 1'b1;
              if (col != '0) begin
                col_next = col - COL_W'(1);
              end else if (row != '0) begin
                row_next = row - ROW_W'(1);
                col_next = COL_W'(COLUMNS - 1);
              end
            end
            OP_TAB: begin
              cmd_pop  = 1'b1;
              load_out = 1'b1;
              if (int'(tab_col) >= COLUMNS) begin
                col_next = '0;
                row_adv  = 1'b1;
              end else begin
                col_next = tab_col[COL_W-1:0];
              end
            end
            OP_CR: begin
              cmd_pop  = 1'b1;
              load_out = 1'b1;
              col_next = '0;
            end
            OP_LF: begin
              cmd_pop  = 1'b1;
              load_out = 1'b1;
              col_next = '0;
              row_adv  = 1'b1;
            end
            OP_CLEAR: begin
              cmd_pop     = 1'b1;
              load_out    = 1'b1;
              row_ok_next = '0;
              top_next    = '0;
              row_next    = '0;
              col_next    = '0;
            end
            OP_READ: begin
              cmd_pop = 1'b1;
              if (!cmd.rd_ok) begin
                load_out = 1'b1;
              end else if (!row_ok[rd_phys]) begin
                load_out  = 1'b1;
                cell_next = {ATTR_BYTE, CH_SPACE};
              end else begin
                mem_re     = 1'b1;
                state_next = ST_READ;
              end
            end
            default: begin
              cmd_pop  = 1'b1;
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load_out   = 1'b1;
        cell_next  = {ATTR_BYTE, rd_data};
        state_next = ST_IDLE;
      end
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(cur_phys, sweep_cnt);
        mem_wdata = CH_SPACE;
        if (int'(sweep_cnt) == COLUMNS - 1) begin
          row_ok_next[cur_phys] = 1'b1;
          state_next = ST_IDLE;
        end else begin
          sweep_next = sweep_cnt + COL_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Moving past the bottom row rotates the ring: the old top row becomes
    // the new bottom row and reads as blank until it is swept.
    if (row_adv) begin
      if (int'(row) == ROWS - 1) begin
        row_ok_next[top] = 1'b0;
        if (int'(top) == ROWS - 1) begin
          top_next = '0;
        end else begin
          top_next = top + ROW_W'(1);
        end
      end else begin
        row_next = row + ROW_W'(1);
      end
    end

    pos_next = CURSOR_W'(int'(row_next) * COLUMNS + int'(col_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row       <= '0;
      col       <= '0;
      top       <= '0;
      row_ok    <= '0;
      sweep_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      row       <= row_next;
      col       <= col_next;
      top       <= top_next;
      row_ok    <= row_ok_next;
      sweep_cnt <= sweep_next;
      out_valid <= load_out || (out_valid && !rsp.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pos  <= pos_next;
      out_cell <= cell_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.cursor_loc = out_pos;
  assign rsp.cell_word  = out_cell;

endmodule

// ===== rtl/core/text_console_cursor_engine_unit.sv =====
// Text console cursor engine: an 80 x 25 character grid with a cursor.
// Requests on req: kind 0 puts a character (backspace, tab, carriage
// return, line feed, printable bytes), kind 1 clears the screen, kind 2
// reads one cell. Each request gives exactly one transfer on rsp with the
// cursor position after the request and, for a read, the cell word.
// A request passes the front register and the queue, and its response is
// held in the result register; a read of a row that holds written text
// also passes the registered screen memory read. The first printable
// character on a row that was blanked by clear or by scrolling first
// sweeps that row, one cell at a time, before it is written; scrolling
// itself only rotates a row ring. Otherwise the back end retires one
// request per cycle while rsp is ready, and a read of written text holds
// it in the read state before it takes the next request.
// Reset is synchronous and takes effect at once: all rows read as blank,
// the cursor is home, and no clearing pass runs.
// When rsp stalls, the result register holds, then the queue and the
// front register fill, and req.ready drops.
// Depends on tcce_pkg, tcce_req_if, tcce_rsp_if and the tcce_* modules.
module text_console_cursor_engine_unit (
  input  logic       clk,
  input  logic       rst,
  tcce_req_if.sink   req,
  tcce_rsp_if.source rsp
);
  import tcce_pkg::*;

  tcce_cmd_t front_cmd;
  logic      front_valid;
  logic      front_ready;
  tcce_cmd_t back_cmd;
  logic      back_valid;
  logic      back_pop;

  tcce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  tcce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_cmd    (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_pop)
  );

  tcce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_pop   (back_pop),
    .rsp       (rsp)
  );

endmodule
